// ===== rtl/lamport_mutex_node_assert.svh =====
// Assertion macros for the mutex node checker.
`ifndef LAMPORT_MUTEX_NODE_ASSERT_SVH
`define LAMPORT_MUTEX_NODE_ASSERT_SVH

// Checked at every edge outside reset.
`define LMX_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define LMX_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/lmx_pkg.sv =====
package lmx_pkg;

    localparam int NODES_DEF  = 8;
    localparam int STAMP_BITS = 16;
    localparam int ID_W       = 3;
    localparam int ID_N       = 8;
    localparam int FILL_CMD_W = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_SELF_ID    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 1'd1;

    localparam logic [1:0] MODE_REQUEST = 2'd0;
    localparam logic [1:0] MODE_MSG     = 2'd1;
    localparam logic [1:0] MODE_EXIT    = 2'd2;

    localparam logic [1:0] MSG_REQUEST = 2'd0;
    localparam logic [1:0] MSG_REPLY   = 2'd1;
    localparam logic [1:0] MSG_RELEASE = 2'd2;

    localparam logic [2:0] EV_SEND     = 3'd0;
    localparam logic [2:0] EV_ENTER    = 3'd1;
    localparam logic [2:0] EV_BAD_REL  = 3'd2;
    localparam logic [2:0] EV_OVERFLOW = 3'd3;
    localparam logic [2:0] EV_EXIT_BAD = 3'd4;

    typedef struct packed {
        logic [STAMP_BITS-1:0] stamp;
        logic [ID_W-1:0]       id;
    } t_entry;

    typedef struct packed {
        logic                  insert;
        logic                  pop;
        t_entry                key;
        logic [FILL_CMD_W-1:0] fill;
        logic [ID_W-1:0]       self_id;
    } t_qcmd;

    function automatic logic [STAMP_BITS-1:0] f_bump(input logic [STAMP_BITS-1:0] c);
        return (&c) ? c : c + 1'b1;
    endfunction

endpackage

// ===== rtl/lmx_in_if.sv =====
interface lmx_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [1:0] msg_kind;
    logic [15:0] msg_stamp;
    logic [2:0] msg_sender;

    modport source (output valid, mode, msg_kind, msg_stamp, msg_sender, input ready);
    modport sink   (input valid, mode, msg_kind, msg_stamp, msg_sender, output ready);
endinterface

// ===== rtl/lmx_out_if.sv =====
interface lmx_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_res;
    logic [1:0]  send_kind;
    logic [2:0]  dest_node;
    logic [15:0] stamp_out;
    logic        last;

    modport source (output valid, event_res, send_kind, dest_node, stamp_out, last,
                    input ready);
    modport sink   (input valid, event_res, send_kind, dest_node, stamp_out, last,
                    output ready);
endinterface

// ===== rtl/lamport_mutex_node.sv =====
// Lamport mutual exclusion node, one item at a time. After the accepting edge an item
// passes through an update, an evaluate and an emit state; a broadcast then walks the ids
// up to the highest peer, and entry adds one more state before ready returns (an ignored
// item goes back to idle after its update), plus any output stalls. Queue ops run in the
// cell row. Reset (synchronous, active low): clock, fill, replies, holding and config
// cleared (self id 0, node count 1); queue contents are not cleared.
module lamport_mutex_node #(
    parameter int NODES = lmx_pkg::NODES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [lmx_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [lmx_pkg::CFG_DATA_W-1:0] i_cfg_data,
    lmx_in_if.sink                         i_in,
    lmx_out_if.source                      o_out
);
    import lmx_pkg::*;

    localparam int FW = $clog2(NODES + 1);

    // sequencer states
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_EXEC  = 6'b000010,
        S_EVAL  = 6'b000100,
        S_EMIT  = 6'b001000,
        S_BCAST = 6'b010000,
        S_ENTER = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // config
    logic [ID_W-1:0] r_self,  n_self;
    logic [3:0]      r_count, n_count;

    // node state
    logic [STAMP_BITS-1:0] r_clock, n_clock;
    logic [FW-1:0]         r_fill,  n_fill;
    logic [ID_N-1:0]       r_mask,  n_mask;
    logic                  r_hold,  n_hold;

    // latched item
    logic [1:0]            r_mode, r_kind;
    logic [STAMP_BITS-1:0] r_stamp;
    logic [ID_W-1:0]       r_sender;

    // pending work of the item
    logic            r_sv,    n_sv;     // one single event queued
    logic [2:0]      r_sev,   n_sev;
    logic [1:0]      r_skind, n_skind;
    logic [ID_W-1:0] r_sdest, n_sdest;
    logic            r_bc,    n_bc;     // broadcast to all peers
    logic [1:0]      r_bkind, n_bkind;
    logic            r_entry, n_entry;
    logic [ID_W-1:0] r_idx,   n_idx;

    // output register
    logic                  r_ov, n_ov;
    logic [2:0]            r_oev, n_oev;
    logic [1:0]            r_okind, n_okind;
    logic [ID_W-1:0]       r_odest, n_odest;
    logic [STAMP_BITS-1:0] r_ostamp, n_ostamp;
    logic                  r_olast, n_olast;

    // cell row
    t_qcmd              w_cmd;
    t_entry             w_ent [NODES];
    logic [NODES-1:0]   w_after;
    logic [NODES-1:0]   w_own;

    logic [3:0]      w_lim;
    logic [ID_N-1:0] w_need;
    logic [ID_N-1:0] w_hi;
    logic            w_later;
    logic            w_full;
    logic            w_own_q;
    logic            w_free;
    logic            w_accept;
    logic [STAMP_BITS-1:0] w_max;

    genvar g;
    generate
        for (g = 0; g < NODES; g++) begin : g_cell
            t_entry w_left, w_right;
            logic   w_left_after;
            if (g == 0) begin : g_first
                assign w_left       = '0;
                assign w_left_after = 1'b0;
            end else begin : g_mid
                assign w_left       = w_ent[g-1];
                assign w_left_after = w_after[g-1];
            end
            if (g == NODES - 1) begin : g_tail
                assign w_right = w_ent[g];
            end else begin : g_body
                assign w_right = w_ent[g+1];
            end
            lmx_cell #(.IDX(g)) u_cell (
                .i_clk        (i_clk),
                .i_cmd        (w_cmd),
                .i_left       (w_left),
                .i_left_after (w_left_after),
                .i_right      (w_right),
                .o_entry      (w_ent[g]),
                .o_after      (w_after[g]),
                .o_own        (w_own[g])
            );
        end
    endgenerate

    // effective count: zero acts as one; ids at or above NODES are never peers
    assign w_lim = (r_count == 4'd0) ? 4'd1 : r_count;
    always_comb begin
        for (int i = 0; i < ID_N; i++) begin
            w_need[i] = (4'(i) < w_lim) && (i < NODES) && (ID_W'(i) != r_self);
        end
    end

    assign w_hi     = {ID_N{1'b1}} << (r_idx + 1'b1);
    assign w_later  = |(w_need & w_hi) && (r_idx != {ID_W{1'b1}});
    assign w_full   = (r_fill == FW'(NODES));
    assign w_own_q  = |w_own;
    assign w_free   = !r_ov || o_out.ready;
    assign w_accept = i_in.valid && i_in.ready;
    assign w_max    = (r_clock > r_stamp) ? r_clock : r_stamp;

    assign i_in.ready = (r_state == S_IDLE);

    assign o_out.valid     = r_ov;
    assign o_out.event_res = r_oev;
    assign o_out.send_kind = r_okind;
    assign o_out.dest_node = r_odest;
    assign o_out.stamp_out = r_ostamp;
    assign o_out.last      = r_olast;

    always_comb begin
        n_state  = r_state;
        n_self   = r_self;
        n_count  = r_count;
        n_clock  = r_clock;
        n_fill   = r_fill;
        n_mask   = r_mask;
        n_hold   = r_hold;
        n_sv     = r_sv;
        n_sev    = r_sev;
        n_skind  = r_skind;
        n_sdest  = r_sdest;
        n_bc     = r_bc;
        n_bkind  = r_bkind;
        n_entry  = r_entry;
        n_idx    = r_idx;
        n_ov     = r_ov && !o_out.ready;
        n_oev    = r_oev;
        n_okind  = r_okind;
        n_odest  = r_odest;
        n_ostamp = r_ostamp;
        n_olast  = r_olast;

        w_cmd.insert    = 1'b0;
        w_cmd.pop       = 1'b0;
        w_cmd.key.stamp = r_stamp;
        w_cmd.key.id    = r_sender;
        w_cmd.fill      = FILL_CMD_W'(r_fill);
        w_cmd.self_id   = r_self;

        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SELF_ID:    n_self  = i_cfg_data[ID_W-1:0];
                CFG_NODE_COUNT: n_count = i_cfg_data;
                default: ;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end

            // apply the item to clock, queue and replies; no entry check yet
            S_EXEC: begin
                n_sv    = 1'b0;
                n_bc    = 1'b0;
                n_state = S_EVAL;
                case (r_mode)
                    MODE_REQUEST: begin
                        if (r_hold || w_own_q) begin
                            n_state = S_IDLE;      // repeated request: ignored
                        end else if (w_full) begin
                            n_sv    = 1'b1;
                            n_sev   = EV_OVERFLOW;
                        end else begin
                            n_clock         = f_bump(r_clock);
                            n_mask          = '0;
                            n_bc            = 1'b1;
                            n_bkind         = MSG_REQUEST;
                            w_cmd.insert    = 1'b1;
                            w_cmd.key.stamp = f_bump(r_clock);
                            w_cmd.key.id    = r_self;
                            n_fill          = r_fill + 1'b1;
                        end
                    end
                    MODE_MSG: begin
                        n_clock = f_bump(w_max);
                        if (!w_need[r_sender]) begin
                            n_state = S_IDLE;      // self or unknown sender
                        end else begin
                            case (r_kind)
                                MSG_REQUEST: begin
                                    if (w_full) begin
                                        n_sv  = 1'b1;
                                        n_sev = EV_OVERFLOW;
                                    end else begin
                                        w_cmd.insert = 1'b1;
                                        n_fill       = r_fill + 1'b1;
                                        n_sv         = 1'b1;
                                        n_sev        = EV_SEND;
                                        n_skind      = MSG_REPLY;
                                        n_sdest      = r_sender;
                                    end
                                end
                                MSG_REPLY: begin
                                    n_mask[r_sender] = 1'b1;
                                end
                                MSG_RELEASE: begin
                                    if (r_fill != '0 && w_ent[0].id == r_sender) begin
                                        w_cmd.pop = 1'b1;
                                        n_fill    = r_fill - 1'b1;
                                    end else begin
                                        n_sv  = 1'b1;
                                        n_sev = EV_BAD_REL;
                                    end
                                end
                                default: ;
                            endcase
                        end
                    end
                    MODE_EXIT: begin
                        if (!r_hold) begin
                            n_sv  = 1'b1;
                            n_sev = EV_EXIT_BAD;
                        end else begin
                            n_bc    = 1'b1;
                            n_bkind = MSG_RELEASE;
                            n_mask  = '0;
                            n_hold  = 1'b0;
                            if (r_fill != '0) begin
                                w_cmd.pop = 1'b1;
                                n_fill    = r_fill - 1'b1;
                            end
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
                if (n_sev != EV_SEND) begin
                    n_skind = MSG_REQUEST;
                    n_sdest = '0;
                end
            end

            // decide entry on the updated state so the last flag is known early
            S_EVAL: begin
                n_entry = !r_hold && r_fill != '0 && w_ent[0].id == r_self &&
                          ((r_mask & w_need) == w_need);
                n_idx   = '0;
                n_state = S_EMIT;
            end

            S_EMIT: begin
                if (!r_sv || w_free) begin
                    if (r_sv) begin
                        n_ov     = 1'b1;
                        n_oev    = r_sev;
                        n_okind  = r_skind;
                        n_odest  = r_sdest;
                        n_ostamp = r_clock;
                        n_olast  = !r_entry && !r_bc;
                    end
                    n_state = r_bc ? S_BCAST : (r_entry ? S_ENTER : S_IDLE);
                end
            end

            // walk ids in order, one send per peer
            S_BCAST: begin
                if (!w_need[r_idx] || w_free) begin
                    if (w_need[r_idx]) begin
                        n_ov     = 1'b1;
                        n_oev    = EV_SEND;
                        n_okind  = r_bkind;
                        n_odest  = r_idx;
                        n_ostamp = r_clock;
                        n_olast  = !w_later && !r_entry;
                    end
                    n_idx = r_idx + 1'b1;
                    if (!w_later) begin
                        n_state = r_entry ? S_ENTER : S_IDLE;
                    end
                end
            end

            S_ENTER: begin
                if (w_free) begin
                    n_clock  = f_bump(r_clock);
                    n_hold   = 1'b1;
                    n_ov     = 1'b1;
                    n_oev    = EV_ENTER;
                    n_okind  = MSG_REQUEST;
                    n_odest  = '0;
                    n_ostamp = f_bump(r_clock);
                    n_olast  = 1'b1;
                    n_state  = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_self  <= '0;
            r_count <= 4'd1;
            r_clock <= '0;
            r_fill  <= '0;
            r_mask  <= '0;
            r_hold  <= 1'b0;
            r_sv    <= 1'b0;
            r_bc    <= 1'b0;
            r_entry <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_self  <= n_self;
            r_count <= n_count;
            r_clock <= n_clock;
            r_fill  <= n_fill;
            r_mask  <= n_mask;
            r_hold  <= n_hold;
            r_sv    <= n_sv;
            r_bc    <= n_bc;
            r_entry <= n_entry;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode   <= i_in.mode;
            r_kind   <= i_in.msg_kind;
            r_stamp  <= i_in.msg_stamp;
            r_sender <= i_in.msg_sender;
        end
        r_sev    <= n_sev;
        r_skind  <= n_skind;
        r_sdest  <= n_sdest;
        r_bkind  <= n_bkind;
        r_idx    <= n_idx;
        r_oev    <= n_oev;
        r_okind  <= n_okind;
        r_odest  <= n_odest;
        r_ostamp <= n_ostamp;
        r_olast  <= n_olast;
    end

endmodule

// ===== rtl/lmx_cell.sv =====
module lmx_cell #(
    parameter int IDX = 0
) (
    input  logic           i_clk,
    input  lmx_pkg::t_qcmd i_cmd,
    input  lmx_pkg::t_entry i_left,
    input  logic           i_left_after,
    input  lmx_pkg::t_entry i_right,
    output lmx_pkg::t_entry o_entry,
    output logic           o_after,
    output logic           o_own
);
    import lmx_pkg::*;

    localparam logic [FILL_CMD_W-1:0] POS = FILL_CMD_W'(IDX);

    t_entry r_ent;
    t_entry n_ent;
    logic   w_occ;

    assign w_occ   = POS < i_cmd.fill;
    // entry sorts after the new key, so it moves one place right on insert
    assign o_after = w_occ && ((r_ent.stamp > i_cmd.key.stamp) ||
                     (r_ent.stamp == i_cmd.key.stamp && r_ent.id > i_cmd.key.id));
    assign o_own   = w_occ && (r_ent.id == i_cmd.self_id);
    assign o_entry = r_ent;

    always_comb begin
        n_ent = r_ent;
        if (i_cmd.pop) begin
            n_ent = i_right;
        end else if (i_cmd.insert) begin
            if (i_left_after) begin
                n_ent = i_left;
            end else if (o_after || POS == i_cmd.fill) begin
                n_ent = i_cmd.key;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
    end

endmodule

// ===== rtl/lmx_checker.sv =====
`include "lamport_mutex_node_assert.svh"

module lmx_sva (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_out_last,
    input logic [15:0] i_out_stamp
);

    `LMX_ASSERT_ALWAYS(a_rst_quiet, i_clk, !i_rst_n |=> !i_out_valid, "result valid after reset")
    `LMX_ASSERT(a_busy, i_clk, i_rst_n, (i_in_valid && i_in_ready) |=> !i_in_ready, "ready after accept")
    `LMX_ASSERT(a_burst, i_clk, i_rst_n, (i_out_valid && !i_out_last) |-> !i_in_ready, "ready mid burst")
    `LMX_ASSERT(a_hold, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_stamp)), "stalled result changed")

endmodule

bind lamport_mutex_node lmx_sva u_lmx_sva (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_last  (o_out.last),
    .i_out_stamp (o_out.stamp_out)
);
